// ----- rtl/core/rate_monotonic_background_scheduler_defines.svh -----
// Assertion macros shared by the scheduler checker.
// No dependencies.
`ifndef RATE_MONOTONIC_BACKGROUND_SCHEDULER_DEFINES_SVH
`define RATE_MONOTONIC_BACKGROUND_SCHEDULER_DEFINES_SVH

// Implication checked in the same cycle.
`define RMBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication checked in the next cycle.
`define RMBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/rmbs_pkg.sv -----
// Shared types and constants of the rate monotonic scheduler.
// No dependencies.
`timescale 1ns / 1ps
package rmbs_pkg;
   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   localparam logic [2:0] OP_LOAD_P = 3'd0;
   localparam logic [2:0] OP_LOAD_A = 3'd1;
   localparam logic [2:0] OP_TICK   = 3'd2;
   localparam logic [2:0] OP_READ_P = 3'd3;
   localparam logic [2:0] OP_READ_A = 3'd4;

   typedef struct packed {
      logic capture;
      logic decode;
      logic load;
      logic pscan;
      logic pwait;
      logic prun;
      logic ascan;
      logic finish;
      logic out_load;
      logic idx_clr;
      logic idx_inc;
      logic idx_best;
   } cmd_type;

   typedef struct packed {
      logic load_ok;
      logic tick_run;
      logic last_p;
      logic last_a;
      logic best_found;
      logic rsp_free;
   } sts_type;

   function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [1:0] a);
      logic [16:0] s;
      s = {1'b0, v} + {15'd0, a};
      return s[16] ? CNT_MAX : s[15:0];
   endfunction
endpackage

// ----- rtl/core/rate_monotonic_background_scheduler.sv -----
// Loads, reads and ticks past the horizon pass from decode straight to the result state;
// a tick within the horizon first runs the periodic, wait and aperiodic slot scans.
// Throughput: one beat in flight; the next is accepted as soon as the result is
// registered, even while that result waits. The three slot scans set the tick time.
// Synchronous active-high reset clears valid bits, counters and CPU state.
// Depends on rmbs_pkg, rmbs_ctrl and rmbs_datapath.
`timescale 1ns / 1ps
module rate_monotonic_background_scheduler
   import rmbs_pkg::*;
#(
   parameter int PERIODIC_SLOTS  = 8,
   parameter int APERIODIC_SLOTS = 8,
   parameter int TIME_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_compute_time,
   input  logic [15:0] req_period_or_arrival,
   input  logic [15:0] req_relative_deadline,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_task_id,
   output logic        rsp_idle,
   output logic        rsp_missed,
   output logic [15:0] rsp_preemptions,
   output logic [15:0] rsp_switches,
   output logic [15:0] rsp_exec_ticks,
   output logic [15:0] rsp_wait_ticks,
   output logic        rsp_done_res,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   rmbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rmbs_datapath #(
      .PERIODIC_SLOTS  (PERIODIC_SLOTS),
      .APERIODIC_SLOTS (APERIODIC_SLOTS),
      .TIME_BITS       (TIME_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_opcode            (req_opcode),
      .req_slot              (req_slot),
      .req_compute_time      (req_compute_time),
      .req_period_or_arrival (req_period_or_arrival),
      .req_relative_deadline (req_relative_deadline),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_task_id           (rsp_task_id),
      .rsp_idle              (rsp_idle),
      .rsp_missed            (rsp_missed),
      .rsp_preemptions       (rsp_preemptions),
      .rsp_switches          (rsp_switches),
      .rsp_exec_ticks        (rsp_exec_ticks),
      .rsp_wait_ticks        (rsp_wait_ticks),
      .rsp_done_res          (rsp_done_res)
   );
endmodule

// ----- rtl/core/rmbs_ctrl.sv -----
// Controller state machine of the scheduler: sequences load, scan and result steps.
// Depends on rmbs_pkg.
`timescale 1ns / 1ps
module rmbs_ctrl
   import rmbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_DECODE = 8'b0000_0010,
      S_PSCAN  = 8'b0000_0100,
      S_PWAIT  = 8'b0000_1000,
      S_PRUN   = 8'b0001_0000,
      S_ASCAN  = 8'b0010_0000,
      S_FINISH = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (sts.tick_run) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_PSCAN;
            end else begin
               cmd.load = sts.load_ok;
               state_in = S_OUT;
            end
         end
         S_PSCAN: begin
            cmd.pscan = 1'b1;
            if (sts.last_p) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_PWAIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_PWAIT: begin
            cmd.pwait = 1'b1;
            if (!sts.last_p) begin
               cmd.idx_inc = 1'b1;
            end else if (sts.best_found) begin
               cmd.idx_best = 1'b1;
               state_in     = S_PRUN;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_ASCAN;
            end
         end
         S_PRUN: begin
            cmd.prun    = 1'b1;
            cmd.idx_clr = 1'b1;
            state_in    = S_ASCAN;
         end
         S_ASCAN: begin
            cmd.ascan = 1'b1;
            if (sts.last_a) begin
               state_in = S_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- rtl/core/rmbs_datapath.sv -----
// Datapath of the scheduler: task slot stores, counters, CPU state and result register.
// Depends on rmbs_pkg; driven by rmbs_ctrl.
`timescale 1ns / 1ps
module rmbs_datapath
   import rmbs_pkg::*;
#(
   parameter int PERIODIC_SLOTS  = 8,
   parameter int APERIODIC_SLOTS = 8,
   parameter int TIME_BITS       = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_compute_time,
   input  logic [15:0] req_period_or_arrival,
   input  logic [15:0] req_relative_deadline,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_task_id,
   output logic        rsp_idle,
   output logic        rsp_missed,
   output logic [15:0] rsp_preemptions,
   output logic [15:0] rsp_switches,
   output logic [15:0] rsp_exec_ticks,
   output logic [15:0] rsp_wait_ticks,
   output logic        rsp_done_res
);
   localparam int P      = PERIODIC_SLOTS;
   localparam int A      = APERIODIC_SLOTS;
   localparam int ALL    = P + A;
   localparam int W      = TIME_BITS + 2;
   localparam int REM_W  = TIME_BITS + 1;
   localparam int MAXS   = (P > A) ? P : A;
   localparam int IDX_W  = (MAXS > 1) ? $clog2(MAXS) : 1;
   localparam int CNT_W  = (ALL > 1) ? $clog2(ALL) : 1;
   localparam int ID_W   = $clog2(ALL + 1);
   localparam logic [ID_W-1:0]  IDLE_ID = '1;
   localparam logic [REM_W-1:0] REM_MAX = '1;

   logic [2:0]       op_ff, slot_ff;
   logic [15:0]      comp_ff, pa_ff, rd_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [TIME_BITS-1:0] tick_ff;
   logic [15:0]      horizon_ff;
   logic             tick_run_ff;

   logic [15:0]      per_compute [P];
   logic [15:0]      per_period [P];
   logic [15:0]      per_rel_deadline [P];
   logic [REM_W-1:0] per_remaining [P];
   logic [W-1:0]     per_abs_deadline [P];
   logic [W-1:0]     per_next_release [P];
   logic [P-1:0]     per_valid_ff;
   logic [15:0]      aper_arrival [A];
   logic [15:0]      aper_remaining [A];
   logic [A-1:0]     aper_valid_ff;
   logic [15:0]      exec_cnt_ff [ALL];
   logic [15:0]      wait_cnt_ff [ALL];

   logic [ID_W-1:0]  cpu_task_ff, last_miss_ff;
   logic [W-1:0]     cpu_left_ff, cpu_dl_ff;
   logic [15:0]      preempt_ff, switch_ff;

   logic             best_found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [15:0]      best_period_ff;
   logic [REM_W-1:0] best_rem_ff;
   logic [W-1:0]     best_dl_ff;

   logic             ran_ff, run_per_ff, run_missed_ff;
   logic [ID_W-1:0]  run_id_ff;
   logic [W-1:0]     run_left_ff, run_dl_ff;

   logic             rsp_valid_ff;
   logic [3:0]       rsp_task_ff;
   logic             rsp_idle_ff, rsp_missed_ff, rsp_done_ff;
   logic [15:0]      rsp_exec_ff, rsp_wait_ff;
   logic [15:0]      rsp_pre_ff, rsp_sw_ff;

   logic slot_p_ok, slot_a_ok, aper_mode;
   logic [CNT_W-1:0] cnt_idx, load_cnt_idx;
   logic [W-1:0] tw, hw;

   assign slot_p_ok = (32'(slot_ff) < P);
   assign slot_a_ok = (32'(slot_ff) < A);
   assign aper_mode = cmd.ascan || (op_ff == OP_READ_A);
   assign cnt_idx   = aper_mode ? CNT_W'(P) + CNT_W'(idx_ff) : CNT_W'(idx_ff);
   assign load_cnt_idx = (op_ff == OP_LOAD_A) ? CNT_W'(P) + CNT_W'(slot_ff)
                                                : CNT_W'(slot_ff);
   assign tw = W'(tick_ff);
   assign hw = W'(horizon_ff);

   assign sts.load_ok  = ((op_ff == OP_LOAD_P) && slot_p_ok) ||
                         ((op_ff == OP_LOAD_A) && slot_a_ok);
   assign sts.tick_run = (op_ff == OP_TICK) && (32'(tick_ff) < 32'(horizon_ff));
   assign sts.last_p   = (idx_ff == IDX_W'(P - 1));
   assign sts.last_a   = (idx_ff == IDX_W'(A - 1));
   assign sts.best_found = best_found_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   // Periodic slot update at the scan index.
   logic             p_v, rel_hit, rel, cand, p_wait;
   logic [REM_W-1:0] p_rem, rem1;
   logic [REM_W:0]   rem_sum;
   logic [W-1:0]     p_abs, p_nr, abs1, abs2, nr1, base;
   logic [15:0]      p_cmp, p_per, p_rd;

   always_comb begin
      p_v     = per_valid_ff[idx_ff];
      p_rem   = per_remaining[idx_ff];
      p_abs   = per_abs_deadline[idx_ff];
      p_nr    = per_next_release[idx_ff];
      p_cmp   = per_compute[idx_ff];
      p_per   = per_period[idx_ff];
      p_rd    = per_rel_deadline[idx_ff];
      rel_hit = (p_nr == tw);
      rel     = rel_hit && ((p_rem == '0) || (p_abs <= tw));
      abs1    = (rel_hit && (p_rem == '0)) ? tw + W'(p_rd) : p_abs;
      rem_sum = {1'b0, p_rem} + (REM_W + 1)'(p_cmp);
      if (rel) begin
         rem1 = (rem_sum > {1'b0, REM_MAX}) ? REM_MAX : rem_sum[REM_W-1:0];
         nr1  = p_nr + W'(p_per);
         base = p_nr + W'(p_rd);
      end else begin
         rem1 = p_rem;
         nr1  = p_nr;
         base = p_nr - W'(p_per) + W'(p_rd);
      end
      abs2   = ((rem1 == REM_W'(p_cmp)) && (abs1 != base)) ? base : abs1;
      cand   = p_v && (rem1 != '0) && (!best_found_ff || (p_per < best_period_ff));
      p_wait = p_v && (p_rem != '0) && !(best_found_ff && (idx_ff == best_idx_ff));
   end

   logic a_ready;
   assign a_ready = aper_valid_ff[idx_ff] && (W'(aper_arrival[idx_ff]) <= tw) &&
                    (aper_remaining[idx_ff] != '0);

   // Commit of the chosen task to the CPU.
   logic [ID_W-1:0] f_id;
   logic [W-1:0]    f_left, f_dl;
   logic [1:0]      sw_add, pre_add;

   always_comb begin
      f_id    = ran_ff ? run_id_ff : IDLE_ID;
      f_left  = ran_ff ? run_left_ff : '0;
      f_dl    = ran_ff ? run_dl_ff : hw;
      sw_add  = '0;
      pre_add = '0;
      if (ran_ff && run_per_ff && (tick_ff != '0) && (last_miss_ff == run_id_ff) &&
          (cpu_dl_ff != run_dl_ff)) begin
         sw_add = 2'd1;
      end
      if (cpu_task_ff == IDLE_ID) begin
         if (f_id != IDLE_ID) begin
            sw_add = sw_add + 2'd1;
         end
      end else if (cpu_task_ff != f_id) begin
         sw_add  = sw_add + 2'd1;
         pre_add = {1'b0, cpu_left_ff != '0} + {1'b0, f_id == IDLE_ID};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= 16'hFFFF;
      end else if (csr_we) begin
         horizon_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_opcode;
         slot_ff <= req_slot;
         comp_ff <= req_compute_time;
         pa_ff   <= req_period_or_arrival;
         rd_ff   <= req_relative_deadline;
      end
      if (cmd.capture) begin
         idx_ff <= IDX_W'(req_slot);
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end else if (cmd.idx_best) begin
         idx_ff <= best_idx_ff;
      end
      if (cmd.decode) begin
         tick_run_ff <= sts.tick_run;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (op_ff == OP_LOAD_P)) begin
         per_compute[slot_ff[IDX_W-1:0]]      <= comp_ff;
         per_period[slot_ff[IDX_W-1:0]]       <= pa_ff;
         per_rel_deadline[slot_ff[IDX_W-1:0]] <= rd_ff;
         per_remaining[slot_ff[IDX_W-1:0]]    <= REM_W'(comp_ff);
         per_abs_deadline[slot_ff[IDX_W-1:0]] <= W'(rd_ff);
         per_next_release[slot_ff[IDX_W-1:0]] <= W'(pa_ff);
      end else if (cmd.pscan && p_v) begin
         per_remaining[idx_ff]    <= rem1;
         per_abs_deadline[idx_ff] <= abs2;
         per_next_release[idx_ff] <= nr1;
      end else if (cmd.prun) begin
         per_remaining[idx_ff] <= best_rem_ff - REM_W'(1);
      end
      if (cmd.load && (op_ff == OP_LOAD_A)) begin
         aper_arrival[slot_ff[IDX_W-1:0]]   <= pa_ff;
         aper_remaining[slot_ff[IDX_W-1:0]] <= comp_ff;
      end else if (cmd.ascan && a_ready && !ran_ff) begin
         aper_remaining[idx_ff] <= aper_remaining[idx_ff] - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         per_valid_ff  <= '0;
         aper_valid_ff <= '0;
      end else if (cmd.load) begin
         if (op_ff == OP_LOAD_P) begin
            per_valid_ff[slot_ff[IDX_W-1:0]] <= 1'b1;
         end else begin
            aper_valid_ff[slot_ff[IDX_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ALL; i++) begin
            exec_cnt_ff[i] <= '0;
            wait_cnt_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         exec_cnt_ff[load_cnt_idx] <= '0;
         wait_cnt_ff[load_cnt_idx] <= '0;
      end else if ((cmd.pwait && p_wait) || (cmd.ascan && a_ready && ran_ff)) begin
         exec_cnt_ff[cnt_idx] <= sat_add(exec_cnt_ff[cnt_idx], 2'd1);
         wait_cnt_ff[cnt_idx] <= sat_add(wait_cnt_ff[cnt_idx], 2'd1);
      end else if (cmd.prun || (cmd.ascan && a_ready)) begin
         exec_cnt_ff[cnt_idx] <= sat_add(exec_cnt_ff[cnt_idx], 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         best_found_ff <= 1'b0;
         ran_ff        <= 1'b0;
      end else if (cmd.pscan && cand) begin
         best_found_ff  <= 1'b1;
         best_idx_ff    <= idx_ff;
         best_period_ff <= p_per;
         best_rem_ff    <= rem1;
         best_dl_ff     <= abs2;
      end else if (cmd.prun) begin
         ran_ff        <= 1'b1;
         run_per_ff    <= 1'b1;
         run_id_ff     <= ID_W'(idx_ff);
         run_left_ff   <= W'(best_rem_ff - REM_W'(1));
         run_dl_ff     <= best_dl_ff;
         run_missed_ff <= (tw >= best_dl_ff);
      end else if (cmd.ascan && a_ready && !ran_ff) begin
         ran_ff        <= 1'b1;
         run_per_ff    <= 1'b0;
         run_id_ff     <= ID_W'(cnt_idx);
         run_left_ff   <= W'(aper_remaining[idx_ff] - 16'd1);
         run_dl_ff     <= hw;
         run_missed_ff <= (tw >= hw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         cpu_task_ff  <= IDLE_ID;
         cpu_left_ff  <= '0;
         cpu_dl_ff    <= '1;
         last_miss_ff <= IDLE_ID;
         preempt_ff   <= '0;
         switch_ff    <= '0;
      end else if (cmd.finish) begin
         tick_ff      <= tick_ff + TIME_BITS'(1);
         cpu_task_ff  <= f_id;
         cpu_left_ff  <= f_left;
         cpu_dl_ff    <= f_dl;
         last_miss_ff <= (ran_ff && run_missed_ff) ? run_id_ff : IDLE_ID;
         preempt_ff   <= sat_add(preempt_ff, pre_add);
         switch_ff    <= sat_add(switch_ff, sw_add);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_task_ff   <= (tick_run_ff && ran_ff) ? run_id_ff[3:0] : 4'd0;
         rsp_idle_ff   <= (op_ff == OP_TICK) && !(tick_run_ff && ran_ff);
         rsp_missed_ff <= tick_run_ff && ran_ff && run_missed_ff;
         rsp_done_ff   <= (op_ff == OP_TICK) && !tick_run_ff;
         rsp_pre_ff    <= preempt_ff;
         rsp_sw_ff     <= switch_ff;
         if (((op_ff == OP_READ_P) && slot_p_ok) || ((op_ff == OP_READ_A) && slot_a_ok)) begin
            rsp_exec_ff <= exec_cnt_ff[cnt_idx];
            rsp_wait_ff <= wait_cnt_ff[cnt_idx];
         end else begin
            rsp_exec_ff <= '0;
            rsp_wait_ff <= '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_task_id     = rsp_task_ff;
   assign rsp_idle        = rsp_idle_ff;
   assign rsp_missed      = rsp_missed_ff;
   assign rsp_preemptions = rsp_pre_ff;
   assign rsp_switches    = rsp_sw_ff;
   assign rsp_exec_ticks  = rsp_exec_ff;
   assign rsp_wait_ticks  = rsp_wait_ff;
   assign rsp_done_res    = rsp_done_ff;
endmodule

// ----- rtl/core/rmbs_checker.sv -----
// Port-level checker of the scheduler and its bind to the top level.
// Depends on rate_monotonic_background_scheduler_defines.svh.
`timescale 1ns / 1ps
`include "rate_monotonic_background_scheduler_defines.svh"
module rmbs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_task_id,
   input logic       rsp_idle,
   input logic       rsp_missed,
   input logic       rsp_done_res
);
   `RMBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RMBS_ASSERT_NOW(a_idle_id, clock, reset, rsp_valid && rsp_idle, rsp_task_id == 4'd0)
   `RMBS_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_done_res, rsp_idle)
   `RMBS_ASSERT_NOW(a_miss_run, clock, reset, rsp_valid && rsp_missed, !rsp_idle)
endmodule

bind rate_monotonic_background_scheduler rmbs_checker u_rmbs_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_task_id  (rsp_task_id),
   .rsp_idle     (rsp_idle),
   .rsp_missed   (rsp_missed),
   .rsp_done_res (rsp_done_res)
);

// ----- tb/rate_monotonic_background_scheduler_tb.sv -----
// Self-checking testbench for the rate monotonic scheduler with background server.
// Drives load, tick and read beats under random idling and checks every result
// against an in-bench scheduler model. Depends on rmbs_pkg and the scheduler RTL.
`timescale 1ns / 1ps
module rate_monotonic_background_scheduler_tb;
   import rmbs_pkg::*;

   localparam logic [4:0] NO_TASK = 5'd31;
   localparam logic [2:0] OP_FIRST_UNUSED = OP_READ_A + 3'd1;
   localparam logic [16:0] REM_SAT = 17'h1FFFF;

   typedef struct {
      logic [2:0]  op;
      logic [2:0]  slot;
      logic [15:0] comp;
      logic [15:0] pa;
      logic [15:0] rd;
   } job_req_type;

   typedef struct {
      logic [3:0]  id;
      logic        idle;
      logic        missed;
      logic [15:0] pre;
      logic [15:0] sw;
      logic [15:0] ex;
      logic [15:0] wt;
      logic        done;
   } sched_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [2:0]  req_slot;
   logic [15:0] req_compute_time;
   logic [15:0] req_period_or_arrival;
   logic [15:0] req_relative_deadline;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [3:0]  rsp_task_id;
   logic        rsp_idle;
   logic        rsp_missed;
   logic [15:0] rsp_preemptions;
   logic [15:0] rsp_switches;
   logic [15:0] rsp_exec_ticks;
   logic [15:0] rsp_wait_ticks;
   logic        rsp_done_res;
   logic        csr_we;
   logic [15:0] csr_wdata;

   rate_monotonic_background_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_slot(req_slot),
      .req_compute_time(req_compute_time),
      .req_period_or_arrival(req_period_or_arrival),
      .req_relative_deadline(req_relative_deadline),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_task_id(rsp_task_id), .rsp_idle(rsp_idle), .rsp_missed(rsp_missed),
      .rsp_preemptions(rsp_preemptions), .rsp_switches(rsp_switches),
      .rsp_exec_ticks(rsp_exec_ticks), .rsp_wait_ticks(rsp_wait_ticks),
      .rsp_done_res(rsp_done_res),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Scheduler model state.
   logic [15:0] m_horizon;
   logic [15:0] m_now;
   logic [15:0] p_comp [8];
   logic [15:0] p_per [8];
   logic [15:0] p_rd [8];
   logic [16:0] p_rem [8];
   logic [17:0] p_dl [8];
   logic [17:0] p_rel [8];
   bit          p_ok [8];
   logic [15:0] a_arr [8];
   logic [15:0] a_rem [8];
   bit          a_ok [8];
   logic [15:0] cnt_exec [16];
   logic [15:0] cnt_wait [16];
   logic [4:0]  cpu_id;
   logic [17:0] cpu_left;
   logic [17:0] cpu_dl;
   logic [4:0]  late_id;
   logic [15:0] pre_cnt;
   logic [15:0] sw_cnt;

   job_req_type   pending_jobs [$];
   sched_rsp_type expected_rsps [$];
   job_req_type   offered;
   int            send_idle;
   int            recv_stall;
   int            errors;
   int            ticks_sent;

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

   function automatic void add_job(input job_req_type j);
      pending_jobs.insert(pending_jobs.size(), j);
   endfunction

   task automatic sched_reset();
      m_horizon = 16'hFFFF;
      m_now = '0;
      for (int i = 0; i < 8; i++) begin
         p_comp[i] = '0; p_per[i] = '0; p_rd[i] = '0; p_rem[i] = '0;
         p_dl[i] = '0; p_rel[i] = '0; p_ok[i] = 0;
         a_arr[i] = '0; a_rem[i] = '0; a_ok[i] = 0;
      end
      for (int i = 0; i < 16; i++) begin
         cnt_exec[i] = '0;
         cnt_wait[i] = '0;
      end
      cpu_id = NO_TASK;
      cpu_left = '0;
      cpu_dl = '1;
      late_id = NO_TASK;
      pre_cnt = '0;
      sw_cnt = '0;
   endtask

   function automatic void cpu_switch(input logic [4:0] id, input logic [17:0] left,
                                      input logic [17:0] dl);
      if (cpu_id == NO_TASK) begin
         cpu_id = id;
         if (id != NO_TASK) sw_cnt = bump(sw_cnt);
      end else if (cpu_id != id) begin
         cpu_id = id;
         sw_cnt = bump(sw_cnt);
         if (cpu_left > 0) pre_cnt = bump(pre_cnt);
         if (id == NO_TASK) pre_cnt = bump(pre_cnt);
      end
      cpu_left = left;
      cpu_dl = dl;
   endfunction

   function automatic void run_tick(inout sched_rsp_type r);
      int          best;
      bit          ran;
      bit          miss;
      bit          rel;
      logic [4:0]  run;
      logic [17:0] base;
      logic [17:0] sum;
      best = -1;
      ran = 0;
      miss = 0;
      run = NO_TASK;
      for (int s = 0; s < 8; s++) begin
         if (!p_ok[s]) continue;
         if (p_rel[s] == {2'b00, m_now}) begin
            rel = 0;
            if (p_rem[s] == 0) begin
               p_dl[s] = {2'b00, m_now} + {2'b00, p_rd[s]};
               rel = 1;
            end else if (p_dl[s] <= {2'b00, m_now}) begin
               rel = 1;
            end
            if (rel) begin
               sum = {1'b0, p_rem[s]} + {2'b00, p_comp[s]};
               p_rem[s] = (sum > {1'b0, REM_SAT}) ? REM_SAT : sum[16:0];
               p_rel[s] = p_rel[s] + {2'b00, p_per[s]};
            end
         end
         base = p_rel[s] - {2'b00, p_per[s]} + {2'b00, p_rd[s]};
         if (p_rem[s] == {1'b0, p_comp[s]} && p_dl[s] != base) p_dl[s] = base;
         if (p_rem[s] > 0 && (best < 0 || p_per[s] < p_per[best])) best = s;
      end
      for (int s = 0; s < 8; s++) begin
         if (p_ok[s] && p_rem[s] > 0 && s != best) begin
            cnt_exec[s] = bump(cnt_exec[s]);
            cnt_wait[s] = bump(cnt_wait[s]);
         end
      end
      if (best >= 0) begin
         if (m_now > 0 && late_id == best[4:0] && cpu_dl != p_dl[best])
            sw_cnt = bump(sw_cnt);
         cpu_switch(best[4:0], {1'b0, p_rem[best]} - 18'd1, p_dl[best]);
         miss = {2'b00, m_now} >= p_dl[best];
         cnt_exec[best] = bump(cnt_exec[best]);
         p_rem[best] = p_rem[best] - 17'd1;
         ran = 1;
         run = best[4:0];
      end
      for (int s = 0; s < 8; s++) begin
         if (!a_ok[s] || a_arr[s] > m_now || a_rem[s] == 0) continue;
         if (ran) begin
            cnt_exec[8 + s] = bump(cnt_exec[8 + s]);
            cnt_wait[8 + s] = bump(cnt_wait[8 + s]);
         end else begin
            run = 5'd8 + s[4:0];
            cpu_switch(run, {2'b00, a_rem[s]} - 18'd1, {2'b00, m_horizon});
            miss = m_now >= m_horizon;
            cnt_exec[8 + s] = bump(cnt_exec[8 + s]);
            a_rem[s] = a_rem[s] - 16'd1;
            ran = 1;
         end
      end
      if (!ran) cpu_switch(NO_TASK, '0, {2'b00, m_horizon});
      late_id = (ran && miss) ? run : NO_TASK;
      m_now = m_now + 16'd1;
      r.id = ran ? run[3:0] : 4'd0;
      r.idle = !ran;
      r.missed = ran && miss;
   endfunction

   function automatic sched_rsp_type schedule_job(input job_req_type j);
      sched_rsp_type r;
      r = '{default: '0};
      case (j.op)
         OP_LOAD_P: begin
            p_comp[j.slot] = j.comp; p_per[j.slot] = j.pa; p_rd[j.slot] = j.rd;
            p_rem[j.slot] = {1'b0, j.comp};
            p_dl[j.slot] = {2'b00, j.rd};
            p_rel[j.slot] = {2'b00, j.pa};
            p_ok[j.slot] = 1;
            cnt_exec[j.slot] = '0;
            cnt_wait[j.slot] = '0;
         end
         OP_LOAD_A: begin
            a_arr[j.slot] = j.pa; a_rem[j.slot] = j.comp; a_ok[j.slot] = 1;
            cnt_exec[8 + j.slot] = '0;
            cnt_wait[8 + j.slot] = '0;
         end
         OP_TICK: begin
            if (m_now >= m_horizon) begin
               r.idle = 1;
               r.done = 1;
            end else begin
               run_tick(r);
            end
         end
         OP_READ_P: begin
            r.ex = cnt_exec[j.slot];
            r.wt = cnt_wait[j.slot];
         end
         OP_READ_A: begin
            r.ex = cnt_exec[8 + j.slot];
            r.wt = cnt_wait[8 + j.slot];
         end
         default: ;
      endcase
      r.pre = pre_cnt;
      r.sw = sw_cnt;
      return r;
   endfunction

   function automatic job_req_type random_job();
      job_req_type j;
      int          pick;
      j.slot = 3'($urandom_range(7));
      j.comp = 16'($urandom_range(6));
      j.pa = 16'($urandom_range(1, 24));
      j.rd = 16'($urandom_range(24));
      pick = $urandom_range(99);
      if (pick < 12) j.op = OP_LOAD_P;
      else if (pick < 20) j.op = OP_LOAD_A;
      else if (pick < 72) j.op = OP_TICK;
      else if (pick < 84) j.op = OP_READ_P;
      else if (pick < 96) j.op = OP_READ_A;
      else j.op = 3'($urandom_range(OP_FIRST_UNUSED, 7));
      if (j.op == OP_LOAD_A) j.pa = 16'(ticks_sent + int'($urandom_range(30)) - 10);
      if ($urandom_range(19) == 0) begin
         j.comp = 16'($urandom);
         j.pa = 16'($urandom);
         j.rd = 16'($urandom);
      end
      if (j.op == OP_TICK) ticks_sent++;
      return j;
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsps.insert(expected_rsps.size(), schedule_job(offered));
         if (!req_valid || req_ready) begin
            if (pending_jobs.size() > 0 && $urandom_range(99) >= send_idle) begin
               offered = pending_jobs.pop_front();
               req_valid <= 1;
               req_opcode <= offered.op;
               req_slot <= offered.slot;
               req_compute_time <= offered.comp;
               req_period_or_arrival <= offered.pa;
               req_relative_deadline <= offered.rd;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      sched_rsp_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_task_id !== e.id || rsp_idle !== e.idle || rsp_missed !== e.missed ||
                   rsp_preemptions !== e.pre || rsp_switches !== e.sw ||
                   rsp_exec_ticks !== e.ex || rsp_wait_ticks !== e.wt ||
                   rsp_done_res !== e.done) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp id%0d i%0d m%0d p%0d s%0d e%0d w%0d d%0d %s",
                              e.id, e.idle, e.missed, e.pre, e.sw, e.ex, e.wt, e.done,
                              $sformatf("got id%0d i%0d m%0d p%0d s%0d e%0d w%0d d%0d",
                                        rsp_task_id, rsp_idle, rsp_missed,
                                        rsp_preemptions, rsp_switches, rsp_exec_ticks,
                                        rsp_wait_ticks, rsp_done_res));
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   task automatic drain();
      do @(negedge clock);
      while (pending_jobs.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_horizon(input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      m_horizon = v;
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
      send_idle = idle_pct;
      recv_stall = stall_pct;
      repeat (count) add_job(random_job());
      drain();
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_opcode = '0;
      req_slot = '0;
      req_compute_time = '0;
      req_period_or_arrival = '0;
      req_relative_deadline = '0;
      rsp_ready = 0;
      csr_we = 0;
      csr_wdata = '0;
      errors = 0;
      ticks_sent = 0;
      send_idle = 0;
      recv_stall = 0;
      sched_reset();
      repeat (11) @(posedge clock);
      reset <= 0;

      add_job('{OP_TICK, 3'd0, 16'd0, 16'd0, 16'd0});
      add_job('{OP_LOAD_P, 3'd0, 16'd2, 16'd4, 16'd3});
      add_job('{OP_LOAD_P, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      add_job('{OP_LOAD_P, 3'd3, 16'd0, 16'd0, 16'd0});
      add_job('{OP_LOAD_P, 3'd1, 16'd3, 16'd2, 16'd1});
      add_job('{OP_LOAD_A, 3'd0, 16'd3, 16'd0, 16'd0});
      add_job('{OP_LOAD_A, 3'd7, 16'hFFFF, 16'd5, 16'hFFFF});
      repeat (8) add_job('{OP_TICK, 3'd0, 16'd0, 16'd0, 16'd0});
      add_job('{OP_READ_P, 3'd0, 16'd0, 16'd0, 16'd0});
      add_job('{OP_READ_P, 3'd7, 16'd0, 16'd0, 16'd0});
      add_job('{OP_READ_A, 3'd0, 16'd0, 16'd0, 16'd0});
      add_job('{OP_READ_A, 3'd7, 16'd0, 16'd0, 16'd0});
      add_job('{OP_FIRST_UNUSED, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      add_job('{3'd7, 3'd5, 16'd0, 16'd0, 16'd0});
      ticks_sent = 9;
      drain();

      run_phase(0, 0, 330);
      write_horizon(16'd1);
      run_phase(65, 0, 150);
      write_horizon(16'hFFFF);
      run_phase(0, 65, 330);
      write_horizon(16'(ticks_sent + 150));
      run_phase(31, 31, 330);
      write_horizon(16'hFFFF);
      run_phase(0, 0, 180);
      write_horizon(16'($urandom_range(1, 65535)));
      run_phase(31, 31, 330);

      if (errors == 0 && expected_rsps.size() == 0)
         $display("rate_monotonic_background_scheduler_tb: clean");
      else
         $display("rate_monotonic_background_scheduler_tb: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("rate_monotonic_background_scheduler_tb: errors");
      $finish;
   end
endmodule
